// ===== hdl/substring_match_counter_macros.svh =====
// ----------------------------------------------------------------------------
// substring_match_counter_macros
// assertion shorthands used by the checker file smc_checker.sv
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_MATCH_COUNTER_MACROS_SVH
`define SUBSTRING_MATCH_COUNTER_MACROS_SVH

// same-cycle implication, disabled in reset
`define SMC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/smc_pkg.sv =====
// ----------------------------------------------------------------------------
// smc_pkg
// shared constants and types of the substring match counter
// ----------------------------------------------------------------------------
`default_nettype none

package smc_pkg;

    localparam int NEEDLE_MAX_DEF = 8;
    localparam int TEXT_MAX_DEF   = 65536;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int POS_W      = 16;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;
    localparam int RES_W      = 1 + 2 * POS_W;

    localparam logic [POS_W-1:0] POS_SAT = {POS_W{1'b1}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDLE_BYTES  = 1'b0,
        REG_NEEDLE_LENGTH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [POS_W-1:0] match_count;
        logic [POS_W-1:0] first_position;
        logic             found;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/substring_match_counter.sv =====
// ----------------------------------------------------------------------------
// substring_match_counter
// streams haystack bytes and counts non-overlapping needle matches
// ----------------------------------------------------------------------------
// output: a haystack's result is registered, when its last item is accepted,
//   into the main output register, or into the skid while m_axis stalls
// throughput: one item per cycle while the skid is empty; window compare and
//   counters update in the accepting cycle, results use a two-entry buffer
// reset: rst_n clears needle registers, scan state and output valids
`default_nettype none

module substring_match_counter
    import smc_pkg::*;
#(
    parameter int NEEDLE_MAX = NEEDLE_MAX_DEF,
    parameter int TEXT_MAX   = TEXT_MAX_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_wdata,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire logic                  s_axis_tuser,   // [0] byte_present
    input  wire logic                  s_axis_tlast,   // is_last
    // result stream
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output      logic [OUT_DATA_W-1:0] m_axis_tdata    // [0] found,
                                                       // [16:1] first_position,
                                                       // [32:17] match_count
);

    localparam int CNT_W  = $clog2(TEXT_MAX + 1);
    localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W + 1;

    // configuration
    logic [CFG_W-1:0] needle_bytes_reg;
    logic [LEN_W-1:0] needle_length_reg;

    // scan state
    logic [BYTE_W-1:0] window_reg   [NEEDLE_MAX];
    logic [BYTE_W-1:0] window_next  [NEEDLE_MAX];
    logic [CNT_W-1:0]  bytes_seen_reg,   bytes_seen_next;
    logic [LEN_W-1:0]  skip_left_reg,    skip_left_next;
    logic [POS_W-1:0]  count_reg,        count_next;
    logic [POS_W-1:0]  first_start_reg,  first_start_next;
    logic              seen_match_reg,   seen_match_next;

    // output buffer
    logic    out_valid_reg,  out_valid_next;
    result_t out_data_reg,   out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg,  skid_data_next;

    logic                  in_xfer;
    logic                  emit;
    logic [LEN_W-1:0]      eff_len;
    logic [NEEDLE_MAX:1]   hit;
    logic                  window_hit;
    logic [WIDE_W-1:0]     start_wide;
    result_t               result;
    logic                  main_free;

    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign emit    = in_xfer && s_axis_tlast;
    assign eff_len = (needle_length_reg > LEN_W'(NEEDLE_MAX)) ?
                     LEN_W'(NEEDLE_MAX) : needle_length_reg;

    // shifted window: newest byte at entry 0
    always_comb
    begin
        for (int i = 0; i < NEEDLE_MAX; i++)
        begin
            window_next[i] = window_reg[i];
        end
        if (in_xfer && s_axis_tuser)
        begin
            for (int i = NEEDLE_MAX - 1; i > 0; i--)
            begin
                window_next[i] = window_reg[i-1];
            end
            window_next[0] = s_axis_tdata[BYTE_W-1:0];
        end
    end

    // compare for every possible needle length in parallel
    always_comb
    begin
        for (int l = 1; l <= NEEDLE_MAX; l++)
        begin
            hit[l] = 1'b1;
            for (int i = 0; i < l; i++)
            begin
                if (window_next[l-1-i] != needle_bytes_reg[BYTE_W*i +: BYTE_W])
                begin
                    hit[l] = 1'b0;
                end
            end
        end
        window_hit = 1'b0;
        for (int l = 1; l <= NEEDLE_MAX; l++)
        begin
            if (eff_len == LEN_W'(l) && hit[l])
            begin
                window_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        bytes_seen_next  = bytes_seen_reg;
        skip_left_next   = skip_left_reg;
        count_next       = count_reg;
        first_start_next = first_start_reg;
        seen_match_next  = seen_match_reg;
        start_wide       = WIDE_W'(bytes_seen_reg) - WIDE_W'(eff_len);

        if (in_xfer && s_axis_tuser)
        begin
            if (bytes_seen_reg < CNT_W'(TEXT_MAX))
            begin
                bytes_seen_next = bytes_seen_reg + CNT_W'(1);
            end
            start_wide = WIDE_W'(bytes_seen_next) - WIDE_W'(eff_len);
            if (eff_len != '0 && bytes_seen_next >= CNT_W'(eff_len))
            begin
                if (skip_left_reg != '0)
                begin
                    skip_left_next = skip_left_reg - LEN_W'(1);
                end
                else if (window_hit)
                begin
                    if (!seen_match_reg)
                    begin
                        first_start_next = (start_wide > WIDE_W'(POS_SAT)) ?
                                           POS_SAT : start_wide[POS_W-1:0];
                        seen_match_next  = 1'b1;
                    end
                    if (count_reg != POS_SAT)
                    begin
                        count_next = count_reg + POS_W'(1);
                    end
                    skip_left_next = eff_len - LEN_W'(1);
                end
            end
        end

        if (eff_len == '0)
        begin
            result.found          = 1'b1;
            result.first_position = '0;
            result.match_count    = '0;
        end
        else
        begin
            result.found          = seen_match_next;
            result.first_position = seen_match_next ? first_start_next : '0;
            result.match_count    = count_next;
        end

        // end of haystack clears the scan
        if (emit)
        begin
            bytes_seen_next  = '0;
            skip_left_next   = '0;
            count_next       = '0;
            first_start_next = '0;
            seen_match_next  = 1'b0;
        end
    end

    // two-entry output buffer: main register plus skid
    assign main_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = emit;
                skid_data_next  = result;
            end
            else
            begin
                out_valid_next = emit;
                out_data_next  = result;
            end
        end
        else if (emit)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - RES_W)'(0), out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_bytes_reg  <= '0;
            needle_length_reg <= '0;
            for (int i = 0; i < NEEDLE_MAX; i++)
            begin
                window_reg[i] <= '0;
            end
            bytes_seen_reg  <= '0;
            skip_left_reg   <= '0;
            count_reg       <= '0;
            first_start_reg <= '0;
            seen_match_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_NEEDLE_BYTES:  needle_bytes_reg  <= cfg_wdata;
                    REG_NEEDLE_LENGTH: needle_length_reg <= cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            for (int i = 0; i < NEEDLE_MAX; i++)
            begin
                window_reg[i] <= emit ? '0 : window_next[i];
            end
            bytes_seen_reg  <= bytes_seen_next;
            skip_left_reg   <= skip_left_next;
            count_reg       <= count_next;
            first_start_reg <= first_start_next;
            seen_match_reg  <= seen_match_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

// ===== hdl/smc_checker.sv =====
// ----------------------------------------------------------------------------
// smc_checker
// port-level checks of the substring match counter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "substring_match_counter_macros.svh"

module smc_checker
    import smc_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic out_stall;
    logic pad_zero;
    logic no_match;
    logic pos_zero;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign pad_zero  = (m_axis_tdata[OUT_DATA_W-1:RES_W] == '0);
    assign no_match  = m_axis_tvalid && !m_axis_tdata[0];
    assign pos_zero  = (m_axis_tdata[POS_W:1] == '0);

    // a pending result is not dropped
    `SMC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid, "result dropped")

    // padding bits above the result stay zero
    `SMC_ASSERT_IMPL(a_pad_zero, clk, rst_n, m_axis_tvalid, pad_zero, "nonzero padding")

    // no match means no position
    `SMC_ASSERT_IMPL(a_pos_none, clk, rst_n, no_match, pos_zero, "position without a match")

    // input only backs off after the result side stalled
    `SMC_ASSERT_IMPL(a_ready_drop, clk, rst_n, $fell(s_axis_tready), $past(out_stall), "bad ready drop")

endmodule

bind substring_match_counter smc_checker u_smc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
